/* hw/rtl/text_console_writer_macros.svh */
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TCW_ASSERT(lbl, prop, msg) `TCW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TCW_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define TCW_ASSERT(lbl, prop, msg)
`endif

`endif

/* hw/rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, request codes and transaction payload types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned CELL_W = 16;

  localparam logic       REQ_PUT      = 1'b0;
  localparam logic       REQ_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic [10:0] cursor_pos;
    logic        did_scroll;
  } rsp_t;

endpackage

/* hw/rtl/tcw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready request and response channels with packed payloads.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned DataWidth = 16,
  parameter int unsigned Depth     = 2000,
  localparam int unsigned AddrW    = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character/attribute screen in RAM with a cursor, scrolling and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries put and read transactions, rsp_o returns one result for
//   each, in order. A put writes char_code with attribute {bg, fg} at the
//   cursor (newline only moves the cursor to the next row start).
//   A read returns the cell at cell_index, or zeros beyond the screen.
// Put, read and scroll:
//   A put without scroll is written and its result is registered at the
//   accepting edge. A read is registered first in the RAM, then in rsp_o.
//   A put at the screen end scrolls first: the single RAM write port copies
//   each cell one row up and fills the last row, then the put is written.
// Reset:
//   The screen RAM is cleared one cell per cycle while req_i.ready stays
//   low. The cursor resets to cell 0.
// Stall:
//   rsp_o holds one result; a new request is taken while it waits if the
//   receiver takes it in the same cycle, otherwise req_i.ready stays low.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_req_if.sink   req_i,
  tcw_rsp_if.source rsp_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned IW    = $clog2(CELLS + 1);
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  localparam logic [IW-1:0] CELLS_V    = IW'(CELLS);
  localparam logic [IW-1:0] COLS_V     = IW'(COLUMNS);
  localparam logic [IW-1:0] LAST_ROW_V = IW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_LAST_V = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } state_e;

  state_e         state_q, state_d;
  logic [IW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  cursor_q, cursor_d;
  logic [CW-1:0]  col_q, col_d;
  logic           pend_q, pend_d;
  logic [AW-1:0]  pa_q, pa_d;
  logic           oor_q, oor_d;
  logic [7:0]     ch_q, ch_d;
  logic [7:0]     attr_q, attr_d;
  logic           out_valid_q, out_valid_d;
  rsp_t           out_q, out_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic          slot_free;
  logic          accept;
  logic          at_end;
  logic [31:0]   idx_ext;
  logic          idx_ok;
  logic [7:0]    step_char;
  logic [7:0]    step_attr;
  logic          step_nl;
  logic [IW-1:0] cur_next;
  logic [CW-1:0] col_next;
  logic [31:0]   cur_ext;
  logic [31:0]   cur_next_ext;
  logic [IW-1:0] copy_dst;
  logic          do_put;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept = req_i.valid && req_i.ready;
  assign at_end = (cursor_q == CELLS_V);

  assign idx_ext = 32'(req_i.data.cell_index);
  assign idx_ok  = idx_ext < 32'(CELLS);

  // Put operands come from the port, or from the held request after a scroll
  assign step_char = (state_q == ST_IDLE) ? req_i.data.char_code : ch_q;
  assign step_attr = (state_q == ST_IDLE) ? {req_i.data.bg_color, req_i.data.fg_color}
                                          : attr_q;
  assign step_nl   = (step_char == NEWLINE_CODE);

  assign cur_next = step_nl ? (cursor_q + (COLS_V - IW'(col_q))) : (cursor_q + IW'(1));
  assign col_next = (step_nl || (col_q == COL_LAST_V)) ? '0 : (col_q + CW'(1));

  assign cur_ext      = 32'(cursor_q);
  assign cur_next_ext = 32'(cur_next);
  assign copy_dst     = cnt_q - COLS_V;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    pend_d      = 1'b0;
    pa_d        = pa_q;
    oor_d       = oor_q;
    ch_d        = ch_q;
    attr_d      = attr_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cursor_q[AW-1:0];
    ram_wdata   = {step_attr, step_char};
    ram_re      = 1'b0;
    ram_raddr   = cnt_q[AW-1:0];
    do_put      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = '0;
        if (cnt_q == CELLS_V - IW'(1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.data.req_type == REQ_READ) begin
            ram_re    = 1'b1;
            ram_raddr = idx_ext[AW-1:0];
            oor_d     = !idx_ok;
            state_d   = ST_RD_WAIT;
          end else if (at_end) begin
            // Hold the request and move the screen up one row first
            ch_d     = req_i.data.char_code;
            attr_d   = {req_i.data.bg_color, req_i.data.fg_color};
            cursor_d = LAST_ROW_V;
            cnt_d    = COLS_V;
            state_d  = ST_COPY;
          end else begin
            do_put = 1'b1;
          end
        end
      end
      ST_RD_WAIT: begin
        out_valid_d      = 1'b1;
        out_d.read_char  = oor_q ? 8'h00 : ram_rdata[7:0];
        out_d.read_attr  = oor_q ? 8'h00 : ram_rdata[15:8];
        out_d.cursor_pos = cur_ext[10:0];
        out_d.did_scroll = 1'b0;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        // Write back the cell read last cycle one row higher
        ram_we    = pend_q;
        ram_waddr = pa_q;
        ram_wdata = ram_rdata;
        if (cnt_q == CELLS_V) begin
          cnt_d   = LAST_ROW_V;
          state_d = ST_FILL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          pend_d    = 1'b1;
          pa_d      = copy_dst[AW-1:0];
          cnt_d     = cnt_q + IW'(1);
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = {8'h00, SPACE_CODE};
        if (cnt_q == CELLS_V - IW'(1)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_FINISH: begin
        do_put  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_put) begin
      ram_we           = !step_nl;
      ram_waddr        = cursor_q[AW-1:0];
      ram_wdata        = {step_attr, step_char};
      cursor_d         = cur_next;
      col_d            = col_next;
      out_valid_d      = 1'b1;
      out_d.read_char  = 8'h00;
      out_d.read_attr  = 8'h00;
      out_d.cursor_pos = cur_next_ext[10:0];
      out_d.did_scroll = (state_q == ST_FINISH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      pend_q      <= 1'b0;
      pa_q        <= '0;
      oor_q       <= 1'b0;
      ch_q        <= '0;
      attr_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      pend_q      <= pend_d;
      pa_q        <= pa_d;
      oor_q       <= oor_d;
      ch_q        <= ch_d;
      attr_q      <= attr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  tcw_ram #(
    .DataWidth(CELL_W),
    .Depth    (CELLS)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  `TCW_ASSERT(a_cursor_range, cursor_q <= CELLS_V, "cursor beyond screen end")
  `TCW_ASSERT(a_col_at_end, (cursor_q == CELLS_V) |-> (col_q == '0), "column not zero at end")
  `TCW_ASSERT(a_col_range, col_q <= COL_LAST_V, "column out of range")
  `TCW_ASSERT(a_fill_exit, (state_q == ST_FILL) |=> (state_q == ST_FILL || state_q == ST_FINISH), "fill left early")

endmodule

/* dv/tcw_console_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the request and response channels, keeps a shadow copy of the
// screen and cursor, predicts each response and compares it in order.
// ----------------------------------------------------------------------------
module tcw_console_checker import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tcw_req_if   req_mon,
  tcw_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned CELLS      = COLUMNS * ROWS;
  localparam int          REPORT_MAX = 10;

  logic [CELL_W-1:0] screen_shadow [CELLS];
  int unsigned       cursor_shadow;
  rsp_t              awaited_results [$];
  int                fail_count = 0;

  // Update the shadow screen for one request and return its response.
  task automatic apply_console_request(input req_t rq, output rsp_t rs);
    logic [7:0] attr;
    rs = '0;
    if (rq.req_type == REQ_PUT) begin
      if (cursor_shadow >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
          screen_shadow[i] = screen_shadow[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
          screen_shadow[i] = {8'h00, SPACE_CODE};
        end
        cursor_shadow -= COLUMNS;
        rs.did_scroll = 1'b1;
      end
      if (rq.char_code == NEWLINE_CODE) begin
        cursor_shadow += COLUMNS - (cursor_shadow % COLUMNS);
      end else begin
        attr = {rq.bg_color, rq.fg_color};
        screen_shadow[cursor_shadow] = {attr, rq.char_code};
        cursor_shadow++;
      end
    end else if (rq.cell_index < CELLS) begin
      rs.read_char = screen_shadow[rq.cell_index][7:0];
      rs.read_attr = screen_shadow[rq.cell_index][15:8];
    end
    rs.cursor_pos = 11'(cursor_shadow);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t expd;
    rsp_t got;
    if (!rst_ni) begin
      foreach (screen_shadow[i]) screen_shadow[i] = '0;
      cursor_shadow = 0;
      awaited_results.delete();
    end else begin
      // Check the response before queuing a request taken at the same edge.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected response char=%0d attr=%0d cur=%0d scr=%0b",
                     $time, got.read_char, got.read_attr, got.cursor_pos, got.did_scroll);
        end else begin
          expd = awaited_results.pop_front();
          if (got.read_char !== expd.read_char || got.read_attr !== expd.read_attr ||
              got.cursor_pos !== expd.cursor_pos || got.did_scroll !== expd.did_scroll) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: response mismatch exp char=%0d attr=%0d cur=%0d scr=%0b, got char=%0d attr=%0d cur=%0d scr=%0b",
                       $time, expd.read_char, expd.read_attr, expd.cursor_pos, expd.did_scroll,
                       got.read_char, got.read_attr, got.cursor_pos, got.did_scroll);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        apply_console_request(req_mon.data, expd);
        awaited_results.push_back(expd);
      end
    end
    pending_o    <= awaited_results.size();
    fail_count_o <= fail_count;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put and read transactions with random idling on both channels,
// long response back-pressure and drain pauses; the checker scores results.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int unsigned CELLS           = COLUMNS_DEF * ROWS_DEF;
  localparam int          PHASE_ITEMS     = 575;
  localparam int          RSP_HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES   = 50;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 15;
  int   recv_idle_pct = 67;
  bit   hold_rsp      = 1'b0;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  tcw_console_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("** text_console_writer: FAILED **");
    $finish;
  end

  function automatic req_t put_request(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    req_t r;
    r.req_type   = REQ_PUT;
    r.char_code  = ch;
    r.fg_color   = fg;
    r.bg_color   = bg;
    r.cell_index = 11'($urandom_range(2047));
    return r;
  endfunction

  function automatic req_t read_request(logic [10:0] idx);
    req_t r;
    r.req_type   = REQ_READ;
    r.char_code  = 8'($urandom_range(255));
    r.fg_color   = 4'($urandom_range(15));
    r.bg_color   = 4'($urandom_range(15));
    r.cell_index = idx;
    return r;
  endfunction

  function automatic req_t random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(9) == 0)
        return read_request(11'($urandom_range(2047, CELLS)));
      return read_request(11'($urandom_range(CELLS - 1)));
    end
    if (pick < 33)
      return put_request(NEWLINE_CODE, 4'($urandom_range(15)), 4'($urandom_range(15)));
    return put_request(8'($urandom_range(255)), 4'($urandom_range(15)),
                       4'($urandom_range(15)));
  endfunction

  // Offer one transaction, idling cycle by cycle first; return at the accepting edge.
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_random_phase(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_rsp = 1'b1;
      send_request(random_request());
    end
  endtask

  initial begin : rsp_drive
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        // Hold off the response side while the sender keeps offering.
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < RSP_HOLD_CYCLES; n++) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset screen, out-of-range reads, color and character extremes.
    send_request(read_request(11'd0));
    send_request(read_request(11'(CELLS - 1)));
    send_request(read_request(11'(CELLS)));
    send_request(read_request(11'd2047));
    send_request(put_request(8'h00, 4'h0, 4'h0));
    send_request(put_request(8'hff, 4'hf, 4'hf));
    send_request(put_request(8'h41, 4'h5, 4'ha));
    send_request(read_request(11'd0));
    send_request(read_request(11'd1));
    send_request(read_request(11'd2));
    send_request(put_request(NEWLINE_CODE, 4'h3, 4'hc));
    send_request(put_request(NEWLINE_CODE, 4'hc, 4'h3));
    send_request(put_request(8'h5a, 4'hf, 4'h0));
    send_request(read_request(11'd160));
    send_request(read_request(11'd80));
    // Fill to the screen end so the next puts scroll, newline first.
    for (int i = 0; i < 23; i++)
      send_request(put_request(NEWLINE_CODE, 4'h1, 4'h2));
    send_request(put_request(NEWLINE_CODE, 4'h7, 4'h8));
    send_request(put_request(8'h42, 4'h0, 4'hf));
    send_request(read_request(11'(CELLS - COLUMNS_DEF)));
    send_request(read_request(11'(CELLS - 1)));

    run_random_phase(PHASE_ITEMS, 200);
    wait_results_drained();

    send_idle_pct = 67;
    recv_idle_pct = 15;
    run_random_phase(PHASE_ITEMS, -1);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PHASE_ITEMS, 100);
    wait_results_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("** text_console_writer: PASSED **");
    else
      $display("** text_console_writer: FAILED **");
    $finish;
  end

endmodule
